/* hdl/nlp_pkg.sv */
// ----------------------------------------------------------------------------
// Number literal parser package
// Transfer types, result format codes and character constants.
// ----------------------------------------------------------------------------
package nlp_pkg;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_type;

   typedef struct packed {
      logic [63:0] value;
      logic [1:0]  format;
   } rsp_type;

   typedef enum logic [1:0] {
      FMT_INVALID = 2'd0,
      FMT_BINARY  = 2'd1,
      FMT_DECIMAL = 2'd2,
      FMT_HEX     = 2'd3
   } format_type;

   typedef struct packed {
      logic x_seen;
      logic zero_seen;
      logic hpre_ok;
      logic hsuf_ok;
      logic dec_ok;
      logic bin_ok;
   } class_flags_type;

   localparam class_flags_type FlagsReset = '{x_seen: 1'b0, zero_seen: 1'b0,
                                              hpre_ok: 1'b1, hsuf_ok: 1'b1,
                                              dec_ok: 1'b1, bin_ok: 1'b1};

   localparam logic [7:0] CharZero   = 8'h30;
   localparam logic [7:0] CharOne    = 8'h31;
   localparam logic [7:0] CharNine   = 8'h39;
   localparam logic [7:0] CharUpperA = 8'h41;
   localparam logic [7:0] CharUpperZ = 8'h5A;
   localparam logic [7:0] CharLowerA = 8'h61;
   localparam logic [7:0] CharLowerB = 8'h62;
   localparam logic [7:0] CharLowerF = 8'h66;
   localparam logic [7:0] CharLowerH = 8'h68;
   localparam logic [7:0] CharLowerX = 8'h78;
   localparam logic [7:0] CaseOffset = 8'h20;

   localparam logic [6:0] BinMaxDigits    = 7'd64;
   localparam logic [6:0] HexMaxDigits    = 7'd16;
   localparam logic [6:0] HexPrefixEnd    = 7'd18;
   localparam logic [6:0] CountSaturation = 7'd127;

endpackage

/* hdl/number_literal_parser.sv */
// ----------------------------------------------------------------------------
// Number literal parser
// Parses a binary, decimal or hexadecimal literal given one character a
// transfer and returns its 64-bit value and format code.
// ----------------------------------------------------------------------------
// Usage: characters of a literal enter on the req_ channel, one per transfer,
// with last_char set on the final one. Upper case letters are folded to lower
// case. After the final character one result leaves on the rsp_ channel with
// the value and a format code (invalid, binary, decimal or hexadecimal).
// Characters that are not final produce no result.
// A character is held in an input register, then a single pass of logic
// updates the per-form accumulators or, for a final character, loads the
// result register.
// One character is taken every cycle unless a final character waits on a
// stalled receiver; the limit is the single accumulator update pass.
// Reset clears the accumulators and flags and empties both registers.
// While the receiver stalls, the held result stays on rsp_data, characters
// that are not final keep flowing, and a final character waits in the input
// register, which then stalls the sender.
// Literals longer than MAX_LEN characters are reported as invalid.
// ----------------------------------------------------------------------------
module number_literal_parser #(
   parameter int unsigned MAX_LEN = 65
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_stall,
   input  nlp_pkg::req_type req_data,
   output logic            rsp_valid,
   input  logic            rsp_stall,
   output nlp_pkg::rsp_type rsp_data
);
   import nlp_pkg::*;

   localparam logic [6:0] MaxLen = 7'(MAX_LEN);

   logic            s1_valid_ff, s1_valid_in;
   req_type         s1_data_ff;
   logic [6:0]      count_ff, count_in;
   logic [63:0]     bin_acc_ff, bin_acc_in;
   logic [63:0]     dec_acc_ff, dec_acc_in;
   logic            dec_ovf_ff, dec_ovf_in;
   logic [63:0]     hsuf_acc_ff, hsuf_acc_in;
   logic [63:0]     hpre_acc_ff, hpre_acc_in;
   class_flags_type flags_ff, flags_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_type         rsp_data_ff, rsp_data_in;

   logic            req_accept;
   logic            out_busy;
   logic            proc;
   logic            last;
   logic [7:0]      c;
   logic            is_dig;
   logic            is_hex;
   logic [3:0]      hval;
   logic [67:0]     dec_next;
   logic [63:0]     bin_upd, dec_upd, hsuf_upd, hpre_upd;
   logic            ovf_upd;
   logic [6:0]      i;
   class_flags_type fl;

   assign out_busy   = rsp_valid_ff && rsp_stall;
   assign last       = s1_data_ff.last_char;
   assign proc       = s1_valid_ff && (!last || !out_busy);
   assign req_stall  = s1_valid_ff && !proc;
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      i = count_ff;
      c = s1_data_ff.char_code;
      if (c >= CharUpperA && c <= CharUpperZ) begin
         c = c + CaseOffset;
      end
      is_dig = (c >= CharZero) && (c <= CharNine);
      is_hex = is_dig || ((c >= CharLowerA) && (c <= CharLowerF));
      hval   = is_dig ? c[3:0] : c[3:0] + 4'd9;

      fl       = flags_ff;
      bin_upd  = bin_acc_ff;
      dec_upd  = dec_acc_ff;
      ovf_upd  = dec_ovf_ff;
      hsuf_upd = hsuf_acc_ff;
      hpre_upd = hpre_acc_ff;

      if (i >= MaxLen) begin
         fl.bin_ok  = 1'b0;
         fl.dec_ok  = 1'b0;
         fl.hsuf_ok = 1'b0;
         fl.hpre_ok = 1'b0;
      end

      if (!last) begin
         if ((c == CharZero || c == CharOne) && i < BinMaxDigits) begin
            bin_upd = {bin_acc_ff[62:0], c[0]};
         end else begin
            fl.bin_ok = 1'b0;
         end
      end else if (c != CharLowerB || i == 7'd0) begin
         fl.bin_ok = 1'b0;
      end

      dec_next = {1'b0, dec_acc_ff, 3'b000} + {3'b000, dec_acc_ff, 1'b0}
               + {64'd0, c[3:0]};
      if (is_dig) begin
         if (!dec_ovf_ff) begin
            if (|dec_next[67:64]) begin
               ovf_upd = 1'b1;
            end else begin
               dec_upd = dec_next[63:0];
            end
         end
      end else begin
         fl.dec_ok = 1'b0;
      end

      if (!last) begin
         if (is_hex && i < HexMaxDigits) begin
            hsuf_upd = {hsuf_acc_ff[59:0], hval};
         end else begin
            fl.hsuf_ok = 1'b0;
         end
      end else if (c != CharLowerH || i == 7'd0) begin
         fl.hsuf_ok = 1'b0;
      end

      if (i == 7'd0) begin
         if (c == CharZero) begin
            fl.zero_seen = 1'b1;
         end
      end else if (i == 7'd1) begin
         if (c == CharLowerX && flags_ff.zero_seen) begin
            fl.x_seen = 1'b1;
         end
      end else if (is_hex && i < HexPrefixEnd) begin
         hpre_upd = {hpre_acc_ff[59:0], hval};
      end else begin
         fl.hpre_ok = 1'b0;
      end

      rsp_data_in.value  = 64'd0;
      rsp_data_in.format = FMT_INVALID;
      if (fl.bin_ok) begin
         rsp_data_in.value  = bin_upd;
         rsp_data_in.format = FMT_BINARY;
      end else if (fl.dec_ok && !ovf_upd) begin
         rsp_data_in.value  = dec_upd;
         rsp_data_in.format = FMT_DECIMAL;
      end else if (fl.hsuf_ok) begin
         rsp_data_in.value  = hsuf_upd;
         rsp_data_in.format = FMT_HEX;
      end else if (fl.hpre_ok && fl.x_seen && i >= 7'd2) begin
         rsp_data_in.value  = hpre_upd;
         rsp_data_in.format = FMT_HEX;
      end

      count_in    = count_ff;
      bin_acc_in  = bin_acc_ff;
      dec_acc_in  = dec_acc_ff;
      dec_ovf_in  = dec_ovf_ff;
      hsuf_acc_in = hsuf_acc_ff;
      hpre_acc_in = hpre_acc_ff;
      flags_in    = flags_ff;
      if (proc) begin
         if (last) begin
            count_in    = 7'd0;
            bin_acc_in  = 64'd0;
            dec_acc_in  = 64'd0;
            dec_ovf_in  = 1'b0;
            hsuf_acc_in = 64'd0;
            hpre_acc_in = 64'd0;
            flags_in    = FlagsReset;
         end else begin
            count_in    = (count_ff < CountSaturation) ? count_ff + 7'd1 : count_ff;
            bin_acc_in  = bin_upd;
            dec_acc_in  = dec_upd;
            dec_ovf_in  = ovf_upd;
            hsuf_acc_in = hsuf_upd;
            hpre_acc_in = hpre_upd;
            flags_in    = fl;
         end
      end

      s1_valid_in  = req_accept || (s1_valid_ff && !proc);
      rsp_valid_in = (proc && last) || out_busy;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         count_ff     <= 7'd0;
         bin_acc_ff   <= 64'd0;
         dec_acc_ff   <= 64'd0;
         dec_ovf_ff   <= 1'b0;
         hsuf_acc_ff  <= 64'd0;
         hpre_acc_ff  <= 64'd0;
         flags_ff     <= FlagsReset;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         bin_acc_ff   <= bin_acc_in;
         dec_acc_ff   <= dec_acc_in;
         dec_ovf_ff   <= dec_ovf_in;
         hsuf_acc_ff  <= hsuf_acc_in;
         hpre_acc_ff  <= hpre_acc_in;
         flags_ff     <= flags_in;
      end
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (proc && last) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // A final character always leaves a cleared parser and a pending result.
   assert property (@(posedge clock) disable iff (reset)
      (proc && last) |=> (count_ff == 7'd0) && rsp_valid_ff)
      else $error("final character did not clear state or load a result");

   // An invalid result always carries a zero value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.format == FMT_INVALID) |-> (rsp_data_ff.value == 64'd0))
      else $error("invalid result with nonzero value");

   // The prefix marker can only follow a leading zero.
   assert property (@(posedge clock) disable iff (reset)
      flags_ff.x_seen |-> flags_ff.zero_seen)
      else $error("prefix marker without leading zero");

   // A pending result that is stalled is never replaced.
   assert property (@(posedge clock) disable iff (reset)
      out_busy |-> !(proc && last))
      else $error("result register overwritten while stalled");

endmodule
